@@ rtl/disc_pkg.sv @@
`timescale 1ns / 1ps

package disc_pkg;

  localparam int TimeoutW = 4;
  localparam int BrightW  = 7;
  localparam int LeadW    = 6;
  localparam int IdleW    = 10;
  localparam int KindW    = 2;
  localparam int PointsW  = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  localparam logic [IdleW-1:0] SecsPerMin = 10'd60;

  localparam logic [TimeoutW-1:0] TimeoutReset = 4'd3;
  localparam logic [BrightW-1:0]  BrightReset  = 7'd100;
  localparam logic [LeadW-1:0]    LeadReset    = 6'd10;
  localparam logic [IdleW-1:0]    IdleReset    = 10'd180;

  localparam logic [BrightW-1:0] BrightMin = 7'd10;
  localparam logic [BrightW-1:0] BrightMax = 7'd100;

  localparam logic [KindW-1:0] KindTick      = 2'd0;
  localparam logic [KindW-1:0] KindTouch     = 2'd1;
  localparam logic [KindW-1:0] KindSleepNow  = 2'd2;
  localparam logic [KindW-1:0] KindKeepAwake = 2'd3;

  localparam logic [CfgIdxW-1:0] RegTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBright  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLead    = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [PointsW-1:0] touch_points;
  } in_item_t;

  typedef struct packed {
    logic [BrightW-1:0] backlight_level;
    logic               display_paused;
    logic               asleep;
    logic               prompt_visible;
    logic               prompt_shown;
    logic               went_to_sleep;
    logic               accept_touch;
    logic [IdleW-1:0]   seconds_left;
  } out_item_t;

endpackage

@@ rtl/disc_if.sv @@
`timescale 1ns / 1ps

interface disc_in_if;
  logic               valid;
  logic               ready;
  disc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface disc_out_if;
  logic                valid;
  logic                ready;
  disc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/display_idle_sleep_controller.sv @@
`timescale 1ns / 1ps

// Display idle-sleep controller. Each transaction on item is a one-second
// tick, a touch report, a sleep-now or a keep-awake request, and gives
// exactly one transaction on result with the display status after that
// event. One item is taken per clock cycle unless result stalls: the
// event is applied to the state flags and idle counter in the accepting
// cycle and the status lands in a single output register; item stays ready
// while that register is empty or being drained. The cfg port writes
// registers 0 timeout minutes (low 4 bits, kept if 0/1/3/5/10), 1
// brightness (kept if 10..100), 2 prompt lead (low 6 bits, kept if nonzero).
// Follow a register write with a keep-awake item to restart the timer.
module display_idle_sleep_controller (
  input  logic                           clk,
  input  logic                           rst,
  disc_in_if.sink                        item,
  disc_out_if.source                     result,
  input  logic                           cfg_we,
  input  logic [disc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [disc_pkg::CfgDataW-1:0]  cfg_data
);

  logic [disc_pkg::TimeoutW-1:0] idle_minutes;
  logic [disc_pkg::BrightW-1:0]  bright_level;
  logic [disc_pkg::LeadW-1:0]    prompt_lead_sec;

  logic                       sleep_flag, sleep_flag_next;
  logic                       prompt_flag, prompt_flag_next;
  logic                       suppress_flag, suppress_flag_next;
  logic [disc_pkg::IdleW-1:0] idle_left, idle_left_next;

  logic                       out_valid;
  disc_pkg::out_item_t        out_data, out_data_next;

  logic                       take;
  logic                       shown, slept;
  logic [disc_pkg::IdleW-1:0] full_idle;
  logic [disc_pkg::IdleW-1:0] idle_dec;
  logic [disc_pkg::TimeoutW-1:0] cfg_timeout;
  logic [disc_pkg::LeadW-1:0]    cfg_lead;

  assign item.ready   = !out_valid || result.ready;
  assign take         = item.valid && item.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign cfg_timeout = cfg_data[disc_pkg::TimeoutW-1:0];
  assign cfg_lead    = cfg_data[disc_pkg::LeadW-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_minutes    <= disc_pkg::TimeoutReset;
      bright_level    <= disc_pkg::BrightReset;
      prompt_lead_sec <= disc_pkg::LeadReset;
    end else if (cfg_we) begin
      case (cfg_index)
        disc_pkg::RegTimeout: begin
          if (cfg_timeout inside {4'd0, 4'd1, 4'd3, 4'd5, 4'd10}) begin
            idle_minutes <= cfg_timeout;
          end
        end
        disc_pkg::RegBright: begin
          if (cfg_data >= disc_pkg::BrightMin && cfg_data <= disc_pkg::BrightMax) begin
            bright_level <= cfg_data;
          end
        end
        disc_pkg::RegLead: begin
          if (cfg_lead != '0) begin
            prompt_lead_sec <= cfg_lead;
          end
        end
        default: ;
      endcase
    end
  end

  assign full_idle = disc_pkg::IdleW'(disc_pkg::IdleW'(idle_minutes) * disc_pkg::SecsPerMin);
  assign idle_dec  = (idle_left != '0) ? idle_left - 1'b1 : idle_left;

  // event handling
  always_comb begin
    sleep_flag_next    = sleep_flag;
    prompt_flag_next   = prompt_flag;
    suppress_flag_next = suppress_flag;
    idle_left_next     = idle_left;
    shown              = 1'b0;
    slept              = 1'b0;
    case (item.data.kind)
      disc_pkg::KindTick: begin
        if (idle_minutes != '0 && !sleep_flag) begin
          idle_left_next = idle_dec;
          if (idle_dec != '0 && idle_dec <= disc_pkg::IdleW'(prompt_lead_sec)) begin
            prompt_flag_next = 1'b1;
            shown            = !prompt_flag;
          end
          if (idle_dec == '0) begin
            sleep_flag_next  = 1'b1;
            prompt_flag_next = 1'b0;
            slept            = 1'b1;
          end
        end
      end
      disc_pkg::KindTouch: begin
        if (item.data.touch_points != '0 && sleep_flag) begin
          sleep_flag_next    = 1'b0;
          prompt_flag_next   = 1'b0;
          suppress_flag_next = 1'b1;
          idle_left_next     = full_idle;
        end else begin
          if (!prompt_flag) begin
            idle_left_next = full_idle;
          end
          if (item.data.touch_points == '0) begin
            suppress_flag_next = 1'b0;
          end
        end
      end
      disc_pkg::KindSleepNow: begin
        slept            = !sleep_flag;
        sleep_flag_next  = 1'b1;
        prompt_flag_next = 1'b0;
        idle_left_next   = '0;
      end
      disc_pkg::KindKeepAwake: begin
        sleep_flag_next    = 1'b0;
        prompt_flag_next   = 1'b0;
        suppress_flag_next = 1'b0;
        idle_left_next     = full_idle;
      end
      default: ;
    endcase

    out_data_next.backlight_level = sleep_flag_next ? '0 : bright_level;
    out_data_next.display_paused  = sleep_flag_next;
    out_data_next.asleep          = sleep_flag_next;
    out_data_next.prompt_visible  = prompt_flag_next;
    out_data_next.prompt_shown    = shown;
    out_data_next.went_to_sleep   = slept;
    out_data_next.accept_touch    = !suppress_flag_next;
    out_data_next.seconds_left    = prompt_flag_next ? idle_left_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_flag    <= 1'b0;
      prompt_flag   <= 1'b0;
      suppress_flag <= 1'b0;
      idle_left     <= disc_pkg::IdleReset;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        sleep_flag    <= sleep_flag_next;
        prompt_flag   <= prompt_flag_next;
        suppress_flag <= suppress_flag_next;
        idle_left     <= idle_left_next;
        out_valid     <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= out_data_next;
    end
  end

`ifndef SYNTHESIS
  a_sleep_no_prompt: assert property (@(posedge clk) disable iff (rst)
    sleep_flag |-> !prompt_flag)
    else $error("prompt flag set while asleep");

  a_prompt_counting: assert property (@(posedge clk) disable iff (rst)
    prompt_flag |-> (idle_left != '0))
    else $error("prompt flag set with idle counter at zero");

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted transaction produced no result");
`endif

endmodule
